[sv/box_filter_row_shrink_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the box filter row shrink block
// Concurrent check wrappers that compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef BOX_FILTER_ROW_SHRINK_DEFINES_SVH
`define BOX_FILTER_ROW_SHRINK_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define BFRS_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define BFRS_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BFRS_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons)
`define BFRS_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons)

`endif

`endif

[sv/bfrs_pkg.sv]
// ---------------------------------------------------------------------------
// Box filter row shrink package
// Widths, reset values, register indexes and the lane control struct.
// ---------------------------------------------------------------------------
package bfrs_pkg;

	// Field and state widths.
	localparam int PIX_W   = 8;
	localparam int CNT_W   = 29;
	localparam int RECIP_W = 16;
	localparam int FRAC_W  = 17;
	// Only the low 24 bits of a channel sum reach the output byte
	// (8 result bits above 16 fraction bits), so the sum is kept that wide.
	localparam int SUM_W   = 24;
	localparam int PART_W  = 9;

	// Number of lanes by default, and the widest supported pixel.
	localparam int CHANNELS_DEF = 4;
	localparam int CHANNELS_MAX = 4;

	// One source pixel (1.0, 16 fraction bits) as a 13.16 counter and a 1.16 weight.
	localparam logic [CNT_W-1:0]  UNIT_CNT  = 29'h0010000;
	localparam logic [FRAC_W-1:0] UNIT_FRAC = 17'h10000;

	// Register reset values.
	localparam logic [CNT_W-1:0]   STEP_RESET  = 29'd131072;
	localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd32768;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RECIP = 2'd1;

	// Per-item control handed from the step counter to every lane.
	typedef struct packed {
		logic              load;   // an item is accepted this cycle
		logic              emit;   // this item closes a destination pixel
		logic              clear;  // row end: sums restart from zero
		logic [FRAC_W-1:0] cnt;    // weight of the pixel inside the closing output
		logic [FRAC_W-1:0] frac;   // leftover weight that seeds the next output
	} ctrl_t;

endpackage

[sv/bfrs_lane.sv]
// ---------------------------------------------------------------------------
// Box filter row shrink lane
// One channel: accumulator, partial weight product and normalizing multiply.
// ---------------------------------------------------------------------------
module bfrs_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bfrs_pkg::PIX_W-1:0]        pix,
	input  bfrs_pkg::ctrl_t                   ctrl,
	input  logic                              s1_load,
	input  logic [bfrs_pkg::RECIP_W-1:0]      recip,
	output logic [bfrs_pkg::PIX_W-1:0]        res
);

	localparam int PROD_W  = bfrs_pkg::PIX_W + bfrs_pkg::FRAC_W;
	localparam int NORM_W  = bfrs_pkg::SUM_W + bfrs_pkg::RECIP_W;

	logic [bfrs_pkg::SUM_W-1:0]  sum_q;
	logic [bfrs_pkg::SUM_W-1:0]  total_s1;
	logic [PROD_W-1:0]           part_prod;
	logic [PROD_W-1:0]           seed_prod;
	logic [bfrs_pkg::PART_W-1:0] part;
	logic [bfrs_pkg::SUM_W-1:0]  total;
	logic [NORM_W-1:0]           norm_prod;

	// Weighted share of this pixel in the closing output and in the next one.
	always_comb begin
		part_prod = PROD_W'(pix) * PROD_W'(ctrl.cnt);
		seed_prod = PROD_W'(pix) * PROD_W'(ctrl.frac);
		part      = part_prod[PROD_W-1:16];
		total     = sum_q + bfrs_pkg::SUM_W'(part);
	end

	// Accumulator: add whole pixels, reseed on an emit, clear at row end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.load) begin
			if (ctrl.clear) begin
				sum_q <= '0;
			end else if (ctrl.emit) begin
				sum_q <= bfrs_pkg::SUM_W'(seed_prod[PROD_W-1:16]);
			end else begin
				sum_q <= sum_q + bfrs_pkg::SUM_W'(pix);
			end
		end
	end

	// Stage 1 holds the unnormalized sum of the closing output.
	always_ff @(posedge clk) begin
		if (s1_load) begin
			total_s1 <= total;
		end
	end

	// Normalize by the reciprocal; the byte sits right above the 16 fraction bits.
	always_comb begin
		norm_prod = NORM_W'(total_s1) * NORM_W'(recip);
		res       = norm_prod[16 +: bfrs_pkg::PIX_W];
	end

endmodule

[sv/bfrs_step_ctrl.sv]
// ---------------------------------------------------------------------------
// Box filter row shrink step counter
// Tracks the source weight still owed to the current destination pixel.
// ---------------------------------------------------------------------------
module bfrs_step_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          row_end,
	input  logic [bfrs_pkg::CNT_W-1:0]    scale_step,
	output bfrs_pkg::ctrl_t               ctrl
);

	logic [bfrs_pkg::CNT_W-1:0]  counter_q;
	logic                        emit;
	logic [bfrs_pkg::FRAC_W-1:0] cnt;
	logic [bfrs_pkg::FRAC_W-1:0] frac;

	// An output closes once one unit or less is owed.
	always_comb begin
		emit = (counter_q <= bfrs_pkg::UNIT_CNT);
		cnt  = counter_q[bfrs_pkg::FRAC_W-1:0];
		frac = bfrs_pkg::UNIT_FRAC - cnt;
	end

	always_comb begin
		ctrl.load  = accept;
		ctrl.emit  = emit;
		ctrl.clear = row_end;
		ctrl.cnt   = cnt;
		ctrl.frac  = frac;
	end

	// Reload with the step less the weight already spent on the next output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= bfrs_pkg::STEP_RESET;
		end else if (accept) begin
			if (row_end) begin
				counter_q <= scale_step;
			end else if (emit) begin
				counter_q <= scale_step - bfrs_pkg::CNT_W'(frac);
			end else begin
				counter_q <= counter_q - bfrs_pkg::UNIT_CNT;
			end
		end
	end

endmodule

[sv/box_filter_row_shrink.sv]
// ---------------------------------------------------------------------------
// Box filter row shrink
// Horizontal area-averaging downscale of 4-channel 8-bit pixels.
// ---------------------------------------------------------------------------
// The block takes one source pixel per clock and gives a destination pixel
// each time the 13.16 step counter runs down to one unit or less; the last
// pixel of a row (tlast) drops any partial output and restarts the counter.
// Each channel has its own lane (accumulator and three multipliers) and the
// lanes are merged into one output register. A result is held in stage 1 and
// then in the output register before it reaches the master side. The
// pixel input keeps taking one item per cycle as long as the output is
// drained; when a result waits at the output and a second one sits in
// stage 1, tready drops until the output is taken. Write scale_step and
// step_reciprocal only while no item is in flight; a new step takes effect
// at the next counter reload.
`include "box_filter_row_shrink_defines.svh"

module box_filter_row_shrink #(
	parameter int CHANNELS = bfrs_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Source pixels.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // chan_a, chan_b, chan_c, chan_d
	input  logic                            s_tlast,   // row_end
	// Destination pixels.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // out_a, out_b, out_c, out_d
	// Register writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfrs_pkg::CNT_W-1:0]      cfg_data
);

	localparam int PW = bfrs_pkg::PIX_W;

	logic [bfrs_pkg::CNT_W-1:0]   scale_step_q;
	logic [bfrs_pkg::RECIP_W-1:0] step_reciprocal_q;
	logic                         emit_s1_q;
	logic                         m_tvalid_q;
	logic [31:0]                  m_tdata_q;
	logic                         out_free;
	logic                         s_accept;
	logic                         s1_load;
	logic [31:0]                  lane_res;
	bfrs_pkg::ctrl_t              ctrl;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_step_q      <= bfrs_pkg::STEP_RESET;
			step_reciprocal_q <= bfrs_pkg::RECIP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				bfrs_pkg::REG_SCALE_STEP: begin
					scale_step_q <= cfg_data;
				end
				bfrs_pkg::REG_STEP_RECIP: begin
					step_reciprocal_q <= cfg_data[bfrs_pkg::RECIP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Flow control: stage 1 only holds items that close an output.
	always_comb begin
		out_free = !m_tvalid_q || m_tready;
		s_tready = !emit_s1_q || out_free;
		s_accept = s_tvalid && s_tready;
	end

	bfrs_step_ctrl u_step_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_accept),
		.row_end    (s_tlast),
		.scale_step (scale_step_q),
		.ctrl       (ctrl)
	);

	assign s1_load = s_accept && ctrl.emit;

	// One lane per active channel; unused channels read as zero.
	for (genvar c = 0; c < bfrs_pkg::CHANNELS_MAX; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			bfrs_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.pix     (s_tdata[c*PW +: PW]),
				.ctrl    (ctrl),
				.s1_load (s1_load),
				.recip   (step_reciprocal_q),
				.res     (lane_res[c*PW +: PW])
			);
		end else begin : g_off
			assign lane_res[c*PW +: PW] = '0;
		end
	end

	// Stage 1 valid and the merged output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				emit_s1_q <= ctrl.emit;
			end else if (out_free) begin
				emit_s1_q <= 1'b0;
			end
			if (out_free) begin
				m_tvalid_q <= emit_s1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit_s1_q) begin
			m_tdata_q <= lane_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// An empty stage 1 never holds off the source.
	`BFRS_ASSERT_IMPL(a_ready_when_s1_empty, clk, arst_n, !emit_s1_q, s_tready)
	// A full stage 1 behind a stalled output blocks the source.
	`BFRS_ASSERT_IMPL(a_block_when_full, clk, arst_n, emit_s1_q && m_tvalid && !m_tready, !s_tready)
	// A closing item is always captured in stage 1.
	`BFRS_ASSERT_NEXT(a_emit_captured, clk, arst_n, s_accept && ctrl.emit, emit_s1_q)

endmodule
